FILE: sv/sclm_pkg.sv
// Shared types, constants and the entry compare function of the command line matcher.
`timescale 1ns / 1ps
`default_nettype none

package sclm_pkg;

  // Defaults for the top-level parameters
  localparam int LineCapacityDefault = 32;
  localparam int EntryCountDefault   = 4;

  // Fixed geometry
  localparam int MaxEntries  = 4;
  localparam int PrefixBytes = 8;
  localparam int TextW       = 8 * PrefixBytes;
  localparam int LenW        = 4;
  localparam int CfgIdxW     = 3;

  localparam logic [7:0] CrByte = 8'h0D;

  // Reset contents of the entry registers ("nop", three bytes)
  localparam logic [TextW-1:0] Entry0TextReset = 64'h0000_0000_0070_6F6E;
  localparam logic [LenW-1:0]  Entry0LenReset  = 4'd3;

  // Register select: index bit 0 picks text or length of an entry
  localparam logic CfgSelText   = 1'b0;
  localparam logic CfgSelLength = 1'b1;

  typedef enum logic [1:0] {
    EV_OVERFLOW = 2'd0,
    EV_MATCH    = 2'd1,
    EV_INVALID  = 2'd2
  } event_kind_e;

  typedef logic [PrefixBytes-1:0][7:0] prefix_t;

  // Job handed from the front to the back
  typedef struct packed {
    logic    overflow;
    prefix_t line;
  } job_t;

  // Front-to-queue push interface
  typedef struct packed {
    logic valid;
    job_t job;
  } push_t;

  // True when the line prefix matches the entry. Compare stops early once
  // both sides hold a zero byte; length zero never matches.
  function automatic logic line_matches(prefix_t line, logic [TextW-1:0] text,
                                        logic [LenW-1:0] len);
    logic [LenW-1:0] n;
    logic            ok;
    logic            zero_seen;
    logic [7:0]      b;
    n         = (len > LenW'(PrefixBytes)) ? LenW'(PrefixBytes) : len;
    ok        = 1'b1;
    zero_seen = 1'b0;
    for (int i = 0; i < PrefixBytes; i++) begin
      b = text[8*i +: 8];
      if (LenW'(i) < n) begin
        if (!(line[i] == b) && !zero_seen) begin
          ok = 1'b0;
        end
      end
      zero_seen = zero_seen | (line[i] == 8'h00);
    end
    return (len != '0) && ok;
  endfunction

endpackage

`default_nettype wire

FILE: sv/sclm_fifo.sv
// Small FIFO that decouples the line collector from the matcher.
`timescale 1ns / 1ps
`default_nettype none

module sclm_fifo #(
  parameter int Width = 8,
  parameter int Depth = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [Width-1:0] push_data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic                  empty_o,
  output logic [Width-1:0]      pop_data_o
);
  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o     = (cnt_q == CntW'(Depth));
  assign empty_o    = (cnt_q == '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

FILE: sv/sclm_front.sv
// Line collector: stores received bytes and issues compare or overflow jobs.
`timescale 1ns / 1ps
`default_nettype none

module sclm_front #(
  parameter int LineCapacity = sclm_pkg::LineCapacityDefault
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire logic [7:0]    rx_byte_i,
  input  wire logic          queue_full_i,
  output sclm_pkg::push_t    push_o
);
  import sclm_pkg::*;

  localparam int CntW = $clog2(LineCapacity + 1);

  logic [CntW-1:0] line_count_q, line_count_d;
  prefix_t         line_prefix_q, line_prefix_d;
  logic            accept, at_capacity, is_cr;

  assign in_ready_o  = !queue_full_i;
  assign accept      = in_valid_i && in_ready_o;
  assign at_capacity = (line_count_q == CntW'(LineCapacity));
  assign is_cr       = (rx_byte_i == CrByte);

  // Job toward the matcher
  always_comb begin
    push_o.valid         = accept && (at_capacity || is_cr);
    push_o.job.overflow  = at_capacity;
    push_o.job.line      = line_prefix_q;
  end

  // Line store update: clear on a finished or overflowed line, else append
  always_comb begin
    line_count_d  = line_count_q;
    line_prefix_d = line_prefix_q;
    if (accept) begin
      if (at_capacity || is_cr) begin
        line_count_d  = '0;
        line_prefix_d = '0;
      end else begin
        line_count_d = line_count_q + 1'b1;
        for (int i = 0; i < PrefixBytes; i++) begin
          if (32'(line_count_q) == i) begin
            line_prefix_d[i] = rx_byte_i;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_count_q  <= '0;
      line_prefix_q <= '0;
    end else begin
      line_count_q  <= line_count_d;
      line_prefix_q <= line_prefix_d;
    end
  end

endmodule

`default_nettype wire

FILE: sv/sclm_back.sv
// Matcher: holds the entry registers, compares queued lines, drives the result register.
`timescale 1ns / 1ps
`default_nettype none

module sclm_back #(
  parameter int EntryCount = sclm_pkg::EntryCountDefault
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [sclm_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [sclm_pkg::TextW-1:0]    cfg_data_i,
  input  wire logic                          queue_empty_i,
  input  wire sclm_pkg::job_t                job_i,
  output logic                               pop_o,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [1:0]                         event_kind_o,
  output logic [1:0]                         entry_index_o
);
  import sclm_pkg::*;

  logic [TextW-1:0] text_q [EntryCount];
  logic [LenW-1:0]  len_q  [EntryCount];
  logic [EntryCount-1:0] hit;

  logic        out_valid_q;
  event_kind_e kind_q, kind_d;
  logic [1:0]  idx_q, idx_d;

  // Entry registers
  for (genvar k = 0; k < EntryCount; k++) begin : g_entry
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        text_q[k] <= (k == 0) ? Entry0TextReset : '0;
        len_q[k]  <= (k == 0) ? Entry0LenReset  : '0;
      end else if (cfg_we_i && (cfg_index_i[CfgIdxW-1:1] == 2'(k))) begin
        if (cfg_index_i[0] == CfgSelText) begin
          text_q[k] <= cfg_data_i;
        end else if (cfg_index_i[0] == CfgSelLength) begin
          len_q[k] <= cfg_data_i[LenW-1:0];
        end
      end
    end

    assign hit[k] = line_matches(job_i.line, text_q[k], len_q[k]);
  end

  // Take a job whenever the result register is free or being drained
  assign pop_o = !queue_empty_i && (!out_valid_q || out_ready_i);

  // First matching entry wins
  always_comb begin
    kind_d = EV_INVALID;
    idx_d  = '0;
    if (job_i.overflow) begin
      kind_d = EV_OVERFLOW;
    end else begin
      for (int k = EntryCount - 1; k >= 0; k--) begin
        if (hit[k]) begin
          kind_d = EV_MATCH;
          idx_d  = 2'(k);
        end
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_o) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      kind_q <= kind_d;
      idx_q  <= idx_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign event_kind_o  = kind_q;
  assign entry_index_o = idx_q;

endmodule

`default_nettype wire

FILE: sv/serial_command_line_matcher.sv
// Serial command line matcher top level: line collector, job queue, matcher.
// Throughput: one received byte per cycle; in_ready_o drops only while the
// two-entry job queue is full, i.e. when results are not being taken.
// After its terminating byte is transferred, a line's job is written to the queue
// and popped into the result register, which then shows the result as valid.
// Reset clears the line store, the queue and the result register at once and
// loads the entry registers with "nop" (length 3) in entry 0, zero elsewhere.
`timescale 1ns / 1ps
`default_nettype none

module serial_command_line_matcher #(
  parameter int LineCapacity = sclm_pkg::LineCapacityDefault,
  parameter int EntryCount   = sclm_pkg::EntryCountDefault
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [7:0]                    rx_byte_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [1:0]                         event_kind_o,
  output logic [1:0]                         entry_index_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [sclm_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [sclm_pkg::TextW-1:0]    cfg_data_i
);
  import sclm_pkg::*;

  localparam int JobW = $bits(job_t);

  push_t           push;
  logic            queue_full, queue_empty, pop;
  logic [JobW-1:0] head_bits;
  job_t            head_job;

  assign head_job = job_t'(head_bits);

  sclm_front #(
    .LineCapacity(LineCapacity)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .rx_byte_i   (rx_byte_i),
    .queue_full_i(queue_full),
    .push_o      (push)
  );

  sclm_fifo #(
    .Width(JobW),
    .Depth(2)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push.valid),
    .push_data_i(push.job),
    .full_o     (queue_full),
    .pop_i      (pop),
    .empty_o    (queue_empty),
    .pop_data_o (head_bits)
  );

  sclm_back #(
    .EntryCount(EntryCount)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .queue_empty_i(queue_empty),
    .job_i        (head_job),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .event_kind_o (event_kind_o),
    .entry_index_o(entry_index_o)
  );

endmodule

`default_nettype wire

FILE: tb/serial_command_line_matcher_tb.sv
// Self-checking testbench of the serial command line matcher: directed and random lines.
`timescale 1ns / 1ps

module serial_command_line_matcher_tb;
  import sclm_pkg::*;

  localparam int LineCap       = LineCapacityDefault;
  localparam int Entries       = EntryCountDefault;
  localparam int RandomBytes   = 1650;
  localparam int HoldOffCycles = 150;
  localparam int SettleCycles  = 6;

  // Expected event of one finished line
  typedef struct {
    event_kind_e kind;
    logic [1:0]  index;
  } line_event_t;

  // Line predictor and store of events still awaited from the block
  class command_event_board;
    logic [TextW-1:0] entry_text [MaxEntries];
    logic [LenW-1:0]  entry_len  [MaxEntries];
    logic [7:0]       line_head  [PrefixBytes];
    int unsigned      line_len;
    line_event_t      awaited_events [$];
    int unsigned      fail_count;

    function new();
      foreach (entry_text[k]) begin
        entry_text[k] = '0;
        entry_len[k]  = '0;
      end
      entry_text[0] = Entry0TextReset;
      entry_len[0]  = Entry0LenReset;
      fail_count    = 0;
      clear_line();
    endfunction

    function void clear_line();
      foreach (line_head[i]) line_head[i] = 8'h00;
      line_len = 0;
    endfunction

    function void write_reg(int idx, logic [TextW-1:0] value);
      if (idx[0] == CfgSelText) entry_text[idx >> 1] = value;
      else entry_len[idx >> 1] = value[LenW-1:0];
    endfunction

    // Prefix compare; stops early once both sides hold a zero byte
    function bit entry_hits(int k);
      int n;
      n = (entry_len[k] > PrefixBytes) ? PrefixBytes : entry_len[k];
      if (entry_len[k] == '0) return 1'b0;
      for (int i = 0; i < n; i++) begin
        if (line_head[i] != entry_text[k][8*i +: 8]) return 1'b0;
        if (line_head[i] == 8'h00) return 1'b1;
      end
      return 1'b1;
    endfunction

    // Note one accepted byte and queue the event it causes, if any
    function void take_byte(logic [7:0] b);
      line_event_t ev;
      if (line_len >= LineCap) begin
        clear_line();
        ev.kind  = EV_OVERFLOW;
        ev.index = 2'd0;
        awaited_events.push_back(ev);
        return;
      end
      if (b == CrByte) begin
        ev.kind  = EV_INVALID;
        ev.index = 2'd0;
        for (int k = 0; k < Entries; k++) begin
          if (entry_hits(k)) begin
            ev.kind  = EV_MATCH;
            ev.index = 2'(k);
            break;
          end
        end
        clear_line();
        awaited_events.push_back(ev);
        return;
      end
      if (line_len < PrefixBytes) line_head[line_len] = b;
      line_len++;
    endfunction

    // Compare one transferred event with the oldest awaited one
    function void match_event(logic [1:0] kind, logic [1:0] index);
      line_event_t ev;
      if (awaited_events.size() == 0) begin
        $error("unexpected event: event_kind=%0d entry_index=%0d", kind, index);
        fail_count++;
        return;
      end
      ev = awaited_events.pop_front();
      if (kind !== ev.kind) begin
        $error("event_kind: expected %0d, actual %0d", ev.kind, kind);
        fail_count++;
      end
      if (index !== ev.index) begin
        $error("entry_index: expected %0d, actual %0d", ev.index, index);
        fail_count++;
      end
    endfunction

    function int pending();
      return awaited_events.size();
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni        = 1'b0;
  logic               in_valid_i    = 1'b0;
  logic               in_ready_o;
  logic [7:0]         rx_byte_i     = 8'h00;
  logic               out_valid_o;
  logic               out_ready_i   = 1'b1;
  logic [1:0]         event_kind_o;
  logic [1:0]         entry_index_o;
  logic               cfg_we_i      = 1'b0;
  logic [CfgIdxW-1:0] cfg_index_i   = '0;
  logic [TextW-1:0]   cfg_data_i    = '0;

  command_event_board board;
  logic [7:0]         tx_line_q [$];
  logic [TextW-1:0]   cfg_text [MaxEntries];
  logic [LenW-1:0]    cfg_len  [MaxEntries];
  int unsigned        bytes_sent   = 0;
  bit                 fast_mode    = 1'b0;
  bit                 hold_off_req = 1'b0;
  bit                 event_taken  = 1'b0;

  serial_command_line_matcher u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .rx_byte_i     (rx_byte_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .event_kind_o  (event_kind_o),
    .entry_index_o (entry_index_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // Result monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      board.match_event(event_kind_o, entry_index_o);
      event_taken = 1'b1;
    end
  end

  // Result sink: random stall after each transfer, one long hold-off on request
  initial begin : result_sink
    int unsigned stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (HoldOffCycles) @(negedge clk_i);
        out_ready_i <= 1'b1;
        stall_left = 0;
      end else if (event_taken) begin
        event_taken = 1'b0;
        stall_left = fast_mode ? 0 : $urandom_range(0, 9);
        out_ready_i <= (stall_left == 0);
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= (stall_left == 0);
      end
    end
  end

  function automatic logic [7:0] alpha_byte();
    return 8'h61 + 8'($urandom_range(0, 3));
  endfunction

  // Offer one byte after a random gap and wait for its transfer
  task automatic push_byte(logic [7:0] b);
    int gap;
    gap = fast_mode ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (!in_ready_o);
    board.take_byte(b);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_line();
    while (tx_line_q.size() > 0) push_byte(tx_line_q.pop_front());
  endtask

  // Let every awaited event arrive, then wait out bytes still in flight
  task automatic settle();
    in_valid_i <= 1'b0;
    while (board.pending() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  // Write all eight registers from cfg_text / cfg_len, one per cycle
  task automatic write_entries();
    logic [TextW-1:0] data;
    for (int idx = 0; idx < 2 * MaxEntries; idx++) begin
      if (idx[0] == CfgSelText) data = cfg_text[idx >> 1];
      else data = {{$urandom, $urandom}} & ~TextW'(4'hF) | TextW'(cfg_len[idx >> 1]);
      cfg_we_i    <= 1'b1;
      cfg_index_i <= CfgIdxW'(idx);
      cfg_data_i  <= data;
      board.write_reg(idx, data);
      @(negedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  task automatic pick_random_entries();
    int mode;
    int n;
    for (int k = 0; k < MaxEntries; k++) begin
      mode        = $urandom_range(0, 5);
      cfg_text[k] = '0;
      case (mode)
        0: begin
          n = $urandom_range(1, 8);
          for (int i = 0; i < n; i++) cfg_text[k][8*i +: 8] = alpha_byte();
          cfg_len[k] = LenW'(n);
        end
        1: begin
          cfg_text[k] = {$urandom, $urandom};
          cfg_len[k]  = LenW'($urandom_range(0, 15));
        end
        2: begin
          cfg_text[k] = '1;
          cfg_len[k]  = $urandom_range(0, 1) ? LenW'(8) : LenW'(15);
        end
        3: cfg_len[k] = LenW'($urandom_range(1, 8));
        4: begin
          // short text, longer length: relies on the zero-byte early stop
          n = $urandom_range(1, 6);
          for (int i = 0; i < n; i++) cfg_text[k][8*i +: 8] = alpha_byte();
          cfg_len[k] = LenW'($urandom_range(n + 1, 15));
        end
        default: begin
          cfg_text[k] = {$urandom, $urandom};
          cfg_len[k]  = '0;
        end
      endcase
    end
  endtask

  // Build one random line in tx_line_q, often close to a programmed entry
  task automatic build_line();
    int kind;
    int k;
    int n;
    logic [7:0] b;
    kind = $urandom_range(0, 99);
    if (kind < 45) begin
      k = $urandom_range(0, MaxEntries - 1);
      n = (board.entry_len[k] > PrefixBytes) ? PrefixBytes : board.entry_len[k];
      if (n == 0) n = $urandom_range(0, PrefixBytes);
      for (int i = 0; i < n; i++) tx_line_q.push_back(board.entry_text[k][8*i +: 8]);
      if (n > 0 && $urandom_range(0, 9) < 3) tx_line_q[$urandom_range(0, n - 1)] = alpha_byte();
      if ($urandom_range(0, 9) < 3) repeat ($urandom_range(1, 4)) tx_line_q.push_back(alpha_byte());
      tx_line_q.push_back(CrByte);
    end else if (kind < 65) begin
      repeat ($urandom_range(0, 10)) tx_line_q.push_back(alpha_byte());
      tx_line_q.push_back(CrByte);
    end else if (kind < 75) begin
      // long line around the capacity: may overflow, possibly on the carriage return
      repeat ($urandom_range(LineCap - 3, LineCap + 4)) begin
        b = 8'($urandom_range(0, 255));
        if (b == CrByte) b = ~b;
        tx_line_q.push_back(b);
      end
      tx_line_q.push_back(CrByte);
    end else if (kind < 85) begin
      repeat ($urandom_range(0, 8)) tx_line_q.push_back($urandom_range(0, 1) ? 8'h00 : alpha_byte());
      tx_line_q.push_back(CrByte);
    end else begin
      repeat ($urandom_range(1, 12)) tx_line_q.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  initial begin : stimulus
    int phase;
    int unsigned phase_end;
    board = new();
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Reset entries: "nop", prefix match, empty line, byte extremes
    tx_line_q = '{8'h6E, 8'h6F, 8'h70, CrByte};
    send_line();
    tx_line_q = '{CrByte};
    send_line();
    tx_line_q = '{8'h6E, 8'h6F, 8'h70, 8'h78, CrByte};
    send_line();
    tx_line_q = '{8'hFF, 8'h00, CrByte};
    send_line();
    settle();

    // Length above eight, disabled entry, zero-byte early stop, all-zero entry
    cfg_text = '{'1, 64'h6261, 64'h6261, '0};
    cfg_len  = '{LenW'(15), LenW'(0), LenW'(5), LenW'(8)};
    write_entries();
    tx_line_q = '{8'h61, 8'h62, CrByte};
    send_line();
    repeat (PrefixBytes) tx_line_q.push_back(8'hFF);
    tx_line_q.push_back(CrByte);
    send_line();
    tx_line_q = '{CrByte};
    send_line();
    settle();

    // Random phases, each with its own entry set
    phase = 0;
    while (bytes_sent < RandomBytes) begin
      phase++;
      pick_random_entries();
      write_entries();
      fast_mode = ($urandom_range(0, 3) == 0);
      if (phase == 3) begin
        // receiver holds off while short lines keep coming: the job queue fills
        fast_mode    = 1'b1;
        hold_off_req = 1'b1;
        repeat (24) begin
          if ($urandom_range(0, 1)) begin
            for (int i = 0; i < cfg_len[0] && i < PrefixBytes; i++)
              tx_line_q.push_back(cfg_text[0][8*i +: 8]);
          end
          tx_line_q.push_back(CrByte);
          send_line();
        end
      end else begin
        phase_end = bytes_sent + $urandom_range(80, 200);
        while (bytes_sent < phase_end) begin
          build_line();
          send_line();
        end
      end
      settle();
    end
    fast_mode = 1'b0;
    settle();

    if (board.fail_count == 0) begin
      $display("[serial_command_line_matcher] OK");
    end else begin
      $display("[serial_command_line_matcher] ERROR");
    end
    $finish;
  end

  // Run limit
  initial begin
    #3_000_000;
    $display("[serial_command_line_matcher] ERROR");
    $finish;
  end

endmodule

FILE: files.f
sv/sclm_pkg.sv
sv/sclm_fifo.sv
sv/sclm_front.sv
sv/sclm_back.sv
sv/serial_command_line_matcher.sv
tb/serial_command_line_matcher_tb.sv
